[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the output safety supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define OSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OSS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/oss_pkg.sv]
// Package with the types, codes and constants of the output safety supervisor.
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

   localparam int TRAINER_CHANNELS = 16;

   localparam logic [13:0] TEST_MIN_MS = 14'd100;
   localparam logic [13:0] TEST_MAX_MS = 14'd10000;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_CHANNEL  = 3'd1;
   localparam logic [2:0] STATUS_LOCKED       = 3'd2;
   localparam logic [2:0] STATUS_BAD_VALUE    = 3'd3;
   localparam logic [2:0] STATUS_BAD_DURATION = 3'd4;

   localparam logic [2:0] REG_HOST_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_SAFE_BURST   = 3'd1;
   localparam logic [2:0] REG_PHONE_HOLD   = 3'd2;
   localparam logic [2:0] REG_PULSE_MIN    = 3'd3;
   localparam logic [2:0] REG_PULSE_MAX    = 3'd4;
   localparam logic [2:0] REG_FIRST_OPEN   = 3'd5;
   localparam logic [2:0] REG_LAST_OPEN    = 3'd6;

   typedef enum logic [3:0] {
      FUNC_TICK       = 4'd0,
      FUNC_ARM        = 4'd1,
      FUNC_DISARM     = 4'd2,
      FUNC_LINK_ON    = 4'd3,
      FUNC_LINK_OFF   = 4'd4,
      FUNC_STOP       = 4'd5,
      FUNC_SAFE       = 4'd6,
      FUNC_PING       = 4'd7,
      FUNC_WRITE      = 4'd8,
      FUNC_TEST       = 4'd9,
      FUNC_RAWTEST    = 4'd10,
      FUNC_PHONE      = 4'd11,
      FUNC_PHONE_STOP = 4'd12,
      FUNC_UNLOCK     = 4'd13,
      FUNC_LOCK       = 4'd14
   } func_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_PHONE = 2'd1,
      KIND_TEST  = 2'd2,
      KIND_STALE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] host_timeout_ms;
      logic [15:0] safe_burst_ms;
      logic [15:0] phone_hold_ms;
      logic [11:0] pulse_min_us;
      logic [11:0] pulse_max_us;
      logic [5:0]  first_open_channel;
      logic [5:0]  last_open_channel;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] now_ms;
      logic [5:0]  host_channel;
      logic [11:0] pulse_us;
      logic [13:0] duration_ms;
      logic        send_enabled;
      logic        deadman_held;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  trainer_channel;
      logic        write_channel;
      logic        load_safe;
      logic        send_safe_frame;
      logic        output_enabled;
      logic        test_active;
      logic        link_enabled;
      logic        phone_active;
      logic [1:0]  timeout_kind;
      logic [31:0] safe_burst_until;
   } rsp_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] trainer_channel;
      logic       pulse_ok;
   } chk_type;

endpackage

`default_nettype wire

[rtl/output_safety_supervisor.sv]
// Top level of the output safety supervisor: request, config and result registers, core.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         req_valid/req_ready  one timestamped event per request
//   rsp_      out        rsp_valid/rsp_ready  one result per request
//   csr_      in         csr_write_enable     register index and write data
//
// One request is accepted per cycle while req_ready is high.
// The request register and the result register each hold one entry, so a stalled
// result still lets one more request be accepted into the request register.
// Mode flags and deadlines are updated in the single cycle a request moves from the
// request register into the result register; config registers follow CSR writes.
// Reset clears the mode flags, deadlines and valid flags and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module output_safety_supervisor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [5:0]  req_host_channel,
   input  wire logic [11:0] req_pulse_us,
   input  wire logic [13:0] req_duration_ms,
   input  wire logic        req_send_enabled,
   input  wire logic        req_deadman_held,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [4:0]  rsp_trainer_channel,
   output      logic        rsp_write_channel,
   output      logic        rsp_load_safe,
   output      logic        rsp_send_safe_frame,
   output      logic        rsp_output_enabled,
   output      logic        rsp_test_active,
   output      logic        rsp_link_enabled,
   output      logic        rsp_phone_active,
   output      logic [1:0]  rsp_timeout_kind,
   output      logic [31:0] rsp_safe_burst_until,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   oss_pkg::cfg_type cfg;
   oss_pkg::req_type req_ff, req_in;
   oss_pkg::rsp_type rsp_ff, rsp_in;
   logic             req_valid_ff, req_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;

   oss_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   oss_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      req_in.func = req_func;
      req_in.now_ms = req_now_ms;
      req_in.host_channel = req_host_channel;
      req_in.pulse_us = req_pulse_us;
      req_in.duration_ms = req_duration_ms;
      req_in.send_enabled = req_send_enabled;
      req_in.deadman_held = req_deadman_held;
      req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_trainer_channel = rsp_ff.trainer_channel;
   assign rsp_write_channel = rsp_ff.write_channel;
   assign rsp_load_safe = rsp_ff.load_safe;
   assign rsp_send_safe_frame = rsp_ff.send_safe_frame;
   assign rsp_output_enabled = rsp_ff.output_enabled;
   assign rsp_test_active = rsp_ff.test_active;
   assign rsp_link_enabled = rsp_ff.link_enabled;
   assign rsp_phone_active = rsp_ff.phone_active;
   assign rsp_timeout_kind = rsp_ff.timeout_kind;
   assign rsp_safe_burst_until = rsp_ff.safe_burst_until;

endmodule

`default_nettype wire

[rtl/oss_cfg_regs.sv]
// Configuration registers of the output safety supervisor.
`timescale 1ns / 1ps
`default_nettype none

module oss_cfg_regs (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write_enable,
   input  wire logic [2:0]     csr_index,
   input  wire logic [15:0]    csr_write_data,
   output oss_pkg::cfg_type    cfg
);

   oss_pkg::cfg_type cfg_ff;
   oss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            oss_pkg::REG_HOST_TIMEOUT: cfg_in.host_timeout_ms = csr_write_data;
            oss_pkg::REG_SAFE_BURST:   cfg_in.safe_burst_ms = csr_write_data;
            oss_pkg::REG_PHONE_HOLD:   cfg_in.phone_hold_ms = csr_write_data;
            oss_pkg::REG_PULSE_MIN:    cfg_in.pulse_min_us = csr_write_data[11:0];
            oss_pkg::REG_PULSE_MAX:    cfg_in.pulse_max_us = csr_write_data[11:0];
            oss_pkg::REG_FIRST_OPEN:   cfg_in.first_open_channel = csr_write_data[5:0];
            oss_pkg::REG_LAST_OPEN:    cfg_in.last_open_channel = csr_write_data[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_timeout_ms    <= 16'd500;
         cfg_ff.safe_burst_ms      <= 16'd1000;
         cfg_ff.phone_hold_ms      <= 16'd300;
         cfg_ff.pulse_min_us       <= 12'd988;
         cfg_ff.pulse_max_us       <= 12'd2012;
         cfg_ff.first_open_channel <= 6'd11;
         cfg_ff.last_open_channel  <= 6'd26;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/oss_chan_check.sv]
// Validation of a host channel write and its mapping onto a trainer channel.
`timescale 1ns / 1ps
`default_nettype none

module oss_chan_check (
   input  wire logic [5:0]     host_channel,
   input  wire logic [11:0]    pulse_us,
   input  wire logic           primary_unlocked,
   input  oss_pkg::cfg_type    cfg,
   output oss_pkg::chk_type    chk
);

   logic       below_open;
   logic       in_open;
   logic [6:0] mapped;

   always_comb begin
      below_open = host_channel < cfg.first_open_channel;
      in_open = !below_open && (host_channel <= cfg.last_open_channel);
      mapped = below_open ? {1'b0, host_channel}
                          : 7'({1'b0, host_channel} - {1'b0, cfg.first_open_channel} + 7'd1);
      chk.pulse_ok = (pulse_us >= cfg.pulse_min_us) && (pulse_us <= cfg.pulse_max_us);
      chk.trainer_channel = 5'd0;
      if (host_channel == 6'd0 || host_channel > cfg.last_open_channel) begin
         chk.status = oss_pkg::STATUS_BAD_CHANNEL;
      end else if (!chk.pulse_ok) begin
         chk.status = oss_pkg::STATUS_BAD_VALUE;
      end else if (!(in_open || (primary_unlocked && below_open))) begin
         chk.status = oss_pkg::STATUS_LOCKED;
      end else if (mapped == 7'd0 || mapped > 7'(oss_pkg::TRAINER_CHANNELS)) begin
         chk.status = oss_pkg::STATUS_BAD_CHANNEL;
      end else begin
         chk.status = oss_pkg::STATUS_OK;
         chk.trainer_channel = mapped[4:0];
      end
   end

endmodule

`default_nettype wire

[rtl/oss_core.sv]
// Mode flags, deadlines and the per-request next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module oss_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  oss_pkg::req_type    req,
   input  oss_pkg::cfg_type    cfg,
   output oss_pkg::rsp_type    rsp
);

   logic        out_on_ff, out_on_in;
   logic        link_on_ff, link_on_in;
   logic        test_on_ff, test_on_in;
   logic        phone_on_ff, phone_on_in;
   logic        unlocked_ff, unlocked_in;
   logic [31:0] last_host_ff, last_host_in;
   logic [31:0] test_dl_ff, test_dl_in;
   logic [31:0] phone_dl_ff, phone_dl_in;
   logic [31:0] burst_dl_ff, burst_dl_in;

   oss_pkg::chk_type chk;

   oss_chan_check u_chan_check (
      .host_channel     (req.host_channel),
      .pulse_us         (req.pulse_us),
      .primary_unlocked (unlocked_ff),
      .cfg              (cfg),
      .chk              (chk)
   );

   always_comb begin
      logic [31:0] now;
      logic [31:0] phone_diff;
      logic [31:0] test_diff;
      logic [31:0] host_age;
      logic [31:0] new_phone_diff;
      logic [31:0] new_test_diff;
      logic [31:0] new_host_age;
      logic        dur_ok;
      logic        do_halt;
      logic        do_start;
      logic        live;

      now = req.now_ms;
      phone_diff = now - phone_dl_ff;
      test_diff = now - test_dl_ff;
      host_age = now - last_host_ff;
      dur_ok = (req.duration_ms >= oss_pkg::TEST_MIN_MS) &&
               (req.duration_ms <= oss_pkg::TEST_MAX_MS);
      do_halt = 1'b0;
      do_start = 1'b0;

      out_on_in = out_on_ff;
      link_on_in = link_on_ff;
      test_on_in = test_on_ff;
      phone_on_in = phone_on_ff;
      unlocked_in = unlocked_ff;
      last_host_in = last_host_ff;
      test_dl_in = test_dl_ff;
      phone_dl_in = phone_dl_ff;
      burst_dl_in = burst_dl_ff;

      rsp.status = oss_pkg::STATUS_OK;
      rsp.trainer_channel = 5'd0;
      rsp.write_channel = 1'b0;
      rsp.load_safe = 1'b0;
      rsp.timeout_kind = oss_pkg::KIND_NONE;

      unique case (oss_pkg::func_type'(req.func))
         oss_pkg::FUNC_TICK: begin
            if (phone_on_ff) begin
               if (!phone_diff[31]) begin
                  do_halt = 1'b1;
                  rsp.timeout_kind = oss_pkg::KIND_PHONE;
               end
            end else if (test_on_ff) begin
               if (!test_diff[31]) begin
                  do_halt = 1'b1;
                  rsp.timeout_kind = oss_pkg::KIND_TEST;
               end
            end else if (out_on_ff && (host_age > {16'd0, cfg.host_timeout_ms})) begin
               do_halt = 1'b1;
               rsp.timeout_kind = oss_pkg::KIND_STALE;
            end
         end
         oss_pkg::FUNC_ARM: begin
            out_on_in = 1'b1;
            test_on_in = 1'b0;
            burst_dl_in = 32'd0;
            last_host_in = now;
         end
         oss_pkg::FUNC_DISARM: do_halt = 1'b1;
         oss_pkg::FUNC_LINK_ON: begin
            link_on_in = 1'b1;
            burst_dl_in = 32'd0;
         end
         oss_pkg::FUNC_LINK_OFF: begin
            link_on_in = 1'b0;
            do_halt = 1'b1;
         end
         oss_pkg::FUNC_STOP: do_halt = 1'b1;
         oss_pkg::FUNC_SAFE: begin
            rsp.load_safe = 1'b1;
            last_host_in = now;
         end
         oss_pkg::FUNC_PING: last_host_in = now;
         oss_pkg::FUNC_WRITE: begin
            rsp.status = chk.status;
            if (chk.status == oss_pkg::STATUS_OK) begin
               rsp.write_channel = 1'b1;
               rsp.trainer_channel = chk.trainer_channel;
               last_host_in = now;
            end
         end
         oss_pkg::FUNC_TEST: begin
            if (!dur_ok) begin
               rsp.status = oss_pkg::STATUS_BAD_DURATION;
            end else begin
               rsp.status = chk.status;
               if (chk.status == oss_pkg::STATUS_OK) begin
                  rsp.write_channel = 1'b1;
                  rsp.trainer_channel = chk.trainer_channel;
                  do_start = 1'b1;
               end
            end
         end
         oss_pkg::FUNC_RAWTEST: begin
            if (req.host_channel == 6'd0 ||
                req.host_channel > 6'(oss_pkg::TRAINER_CHANNELS)) begin
               rsp.status = oss_pkg::STATUS_BAD_CHANNEL;
            end else if (!dur_ok) begin
               rsp.status = oss_pkg::STATUS_BAD_DURATION;
            end else if (!chk.pulse_ok) begin
               rsp.status = oss_pkg::STATUS_BAD_VALUE;
            end else begin
               rsp.write_channel = 1'b1;
               rsp.trainer_channel = req.host_channel[4:0];
               do_start = 1'b1;
            end
         end
         oss_pkg::FUNC_PHONE: begin
            if (!req.send_enabled || !req.deadman_held) begin
               if (out_on_ff || test_on_ff) begin
                  do_halt = 1'b1;
               end else begin
                  rsp.load_safe = 1'b1;
               end
            end else begin
               out_on_in = 1'b1;
               phone_on_in = 1'b1;
               test_on_in = 1'b0;
               link_on_in = 1'b0;
               burst_dl_in = 32'd0;
               last_host_in = now;
               phone_dl_in = now + {16'd0, cfg.phone_hold_ms};
            end
         end
         oss_pkg::FUNC_PHONE_STOP: begin
            if (phone_on_ff || out_on_ff || test_on_ff) begin
               do_halt = 1'b1;
            end
         end
         oss_pkg::FUNC_UNLOCK: unlocked_in = 1'b1;
         oss_pkg::FUNC_LOCK: begin
            unlocked_in = 1'b0;
            do_halt = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_start) begin
         out_on_in = 1'b1;
         test_on_in = 1'b1;
         burst_dl_in = 32'd0;
         test_dl_in = now + {18'd0, req.duration_ms};
         last_host_in = now;
      end

      if (do_halt) begin
         out_on_in = 1'b0;
         phone_on_in = 1'b0;
         test_on_in = 1'b0;
         test_dl_in = 32'd0;
         phone_dl_in = 32'd0;
         rsp.load_safe = 1'b1;
         burst_dl_in = now + {16'd0, cfg.safe_burst_ms};
      end

      new_phone_diff = now - phone_dl_in;
      new_test_diff = now - test_dl_in;
      new_host_age = now - last_host_in;
      live = (out_on_in && ((new_host_age <= {16'd0, cfg.host_timeout_ms}) ||
                            (test_on_in && new_test_diff[31]))) || link_on_in;
      rsp.send_safe_frame = phone_on_in ? !new_phone_diff[31] : !live;

      rsp.output_enabled = out_on_in;
      rsp.test_active = test_on_in;
      rsp.link_enabled = link_on_in;
      rsp.phone_active = phone_on_in;
      rsp.safe_burst_until = burst_dl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_on_ff <= 1'b0;
         link_on_ff <= 1'b0;
         test_on_ff <= 1'b0;
         phone_on_ff <= 1'b0;
         unlocked_ff <= 1'b0;
         last_host_ff <= 32'd0;
         test_dl_ff <= 32'd0;
         phone_dl_ff <= 32'd0;
         burst_dl_ff <= 32'd0;
      end else if (step) begin
         out_on_ff <= out_on_in;
         link_on_ff <= link_on_in;
         test_on_ff <= test_on_in;
         phone_on_ff <= phone_on_in;
         unlocked_ff <= unlocked_in;
         last_host_ff <= last_host_in;
         test_dl_ff <= test_dl_in;
         phone_dl_ff <= phone_dl_in;
         burst_dl_ff <= burst_dl_in;
      end
   end

endmodule

`default_nettype wire

[rtl/oss_checker.sv]
// Port-level assertions for the output safety supervisor and their binding.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module oss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [3:0]  req_func,
   input wire logic [31:0] req_now_ms,
   input wire logic [5:0]  req_host_channel,
   input wire logic [11:0] req_pulse_us,
   input wire logic [13:0] req_duration_ms,
   input wire logic        req_send_enabled,
   input wire logic        req_deadman_held,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [4:0]  rsp_trainer_channel,
   input wire logic        rsp_write_channel,
   input wire logic        rsp_load_safe,
   input wire logic        rsp_send_safe_frame,
   input wire logic        rsp_output_enabled,
   input wire logic        rsp_test_active,
   input wire logic        rsp_link_enabled,
   input wire logic        rsp_phone_active,
   input wire logic [1:0]  rsp_timeout_kind,
   input wire logic [31:0] rsp_safe_burst_until,
   input wire logic        csr_write_enable,
   input wire logic [2:0]  csr_index,
   input wire logic [15:0] csr_write_data
);

   `OSS_ASSERT_ALWAYS(a_no_result_after_reset, reset |=> !rsp_valid, "Result valid after reset")

   `OSS_ASSERT(a_stalled_result_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_safe_burst_until), "Stalled result changed")

   `OSS_ASSERT(a_write_is_ok, rsp_valid && rsp_write_channel |-> rsp_status == oss_pkg::STATUS_OK && rsp_trainer_channel != 5'd0, "Channel write without a good status")

   `OSS_ASSERT(a_failure_writes_nothing, rsp_valid && rsp_status != oss_pkg::STATUS_OK |-> !rsp_write_channel && rsp_trainer_channel == 5'd0, "Failed request writes a channel")

   `OSS_ASSERT(a_modes_need_output, rsp_valid && (rsp_test_active || rsp_phone_active) |-> rsp_output_enabled, "Test or phone mode without output enabled")

endmodule

bind output_safety_supervisor oss_checker u_oss_checker (.*);

`default_nettype wire
